/* rtl/page_frame_pool_lru_unit_defines.svh */
// Assertion macros shared by the pool modules
`ifndef PAGE_FRAME_POOL_LRU_UNIT_DEFINES_SVH
`define PAGE_FRAME_POOL_LRU_UNIT_DEFINES_SVH

// Implication that must hold at every edge out of reset
`define PFP_ASSERT_IMP(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked at the next edge
`define PFP_ASSERT_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/pfpl_pkg.sv */
`default_nettype none
package pfpl_pkg;
	localparam int NUM_FRAMES = 16;
	localparam int PIN_BITS   = 16;
	localparam int FRAME_W    = 6;
	localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

	typedef logic [2:0] func_t;
	localparam func_t FUNC_FETCH     = 3'd0;
	localparam func_t FUNC_NEW       = 3'd1;
	localparam func_t FUNC_UNPIN     = 3'd2;
	localparam func_t FUNC_FLUSH     = 3'd3;
	localparam func_t FUNC_FLUSH_ALL = 3'd4;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_NO_FRAME  = 3'd1;
	localparam status_t ST_NOT_RES   = 3'd2;
	localparam status_t ST_NOT_PIN   = 3'd3;
	localparam status_t ST_PIN_LIMIT = 3'd4;

	// order list command from the controller
	typedef struct packed {
		logic             remove;
		logic             push;
		logic             pop;
		logic [IDX_W-1:0] frame;
	} ord_cmd_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
		logic [IDX_W-1:0] victim;
	} ord_stat_t;
endpackage
`default_nettype wire

/* rtl/page_frame_pool_lru_unit.sv */
// Page buffer pool metadata engine with LRU replacement over 16 frames. One
// request is taken at a time; ready drops while it is worked. A lookup scans
// frames one per cycle through a single 32-bit comparator, a fetch hit on an
// unpinned frame then walks the eviction list one entry per cycle, and
// flush-all scans all frames once, one result per dirty frame (one empty
// result if none is dirty). Results wait in an output register; last marks
// the final result of each request.
`default_nettype none
`include "page_frame_pool_lru_unit_defines.svh"
module page_frame_pool_lru_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire  [2:0]           func,
	input  wire  [31:0]          page_number,
	input  wire                  mark_dirty,
	input  wire  [31:0]          fresh_page_number,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [2:0]           status,
	output logic [5:0]           frame_index,
	output logic                 write_back_valid,
	output logic [31:0]          write_back_page,
	output logic [5:0]           write_back_frame,
	output logic                 read_valid,
	output logic [31:0]          read_page,
	output logic                 zero_fill,
	output logic                 last
);
	import pfpl_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_WAIT_ORD, S_FLUSH, S_OUT} state_t;

	state_t           state_q;
	func_t            func_q;
	logic [31:0]      page_q;
	logic             dirty_in_q;
	logic [CNT_W-1:0] idx_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_f_q;
	logic             done_q;

	logic [31:0]         frame_page_q [NUM_FRAMES];
	logic [NUM_FRAMES-1:0] valid_q, fdirty_q;
	logic [PIN_BITS-1:0] pin_q [NUM_FRAMES];

	ord_cmd_t  ocmd;
	ord_stat_t ostat;

	pfpl_order u_order (.clk(clk), .arst_n(arst_n), .cmd(ocmd), .stat(ostat));

	logic [IDX_W-1:0] si;
	logic             smatch;
	assign si     = idx_q[IDX_W-1:0];
	assign smatch = valid_q[si] && frame_page_q[si] == page_q;
	assign in_ready = (state_q == S_IDLE);

	logic [NUM_FRAMES-1:0] dirty_mask, low_mask;
	logic                  more_dirty;
	assign dirty_mask = valid_q & fdirty_q;
	// frames at or below the scan position
	assign low_mask   = ((NUM_FRAMES'(1) << si) << 1) - NUM_FRAMES'(1);
	assign more_dirty = |(dirty_mask & ~low_mask);

	logic [IDX_W-1:0] vic;
	logic             vic_wb;
	assign vic    = ostat.victim;
	assign vic_wb = valid_q[vic] && fdirty_q[vic];

	always_comb begin
		ocmd = '0;
		if (state_q == S_ACT) begin
			unique case (func_q)
				FUNC_FETCH: begin
					if (hit_q) begin
						ocmd.remove = (pin_q[hit_f_q] == '0);
						ocmd.frame  = hit_f_q;
					end else ocmd.pop = 1'b1;
				end
				FUNC_NEW: ocmd.pop = 1'b1;
				FUNC_UNPIN: begin
					ocmd.push  = hit_q && pin_q[hit_f_q] == PIN_BITS'(1);
					ocmd.frame = hit_f_q;
				end
				default: ;
			endcase
		end
	end

	task automatic set_res(input status_t st, input logic [5:0] fi, input logic wbv,
			input logic [31:0] wbp, input logic [5:0] wbf, input logic rv,
			input logic [31:0] rp, input logic zf, input logic lst);
		status           <= st;
		frame_index      <= fi;
		write_back_valid <= wbv;
		write_back_page  <= wbp;
		write_back_frame <= wbf;
		read_valid       <= rv;
		read_page        <= rp;
		zero_fill        <= zf;
		last             <= lst;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			valid_q   <= '0;
			fdirty_q  <= '0;
			for (int i = 0; i < NUM_FRAMES; i++) pin_q[i] <= '0;
			idx_q     <= '0;
			hit_q     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					func_q     <= func;
					dirty_in_q <= mark_dirty;
					page_q     <= (func == FUNC_NEW) ? fresh_page_number : page_number;
					idx_q      <= '0;
					hit_q      <= 1'b0;
					unique case (func)
						FUNC_FETCH, FUNC_UNPIN, FUNC_FLUSH: state_q <= S_SCAN;
						FUNC_NEW: state_q <= S_ACT;
						FUNC_FLUSH_ALL: state_q <= S_FLUSH;
						default: state_q <= S_IDLE;
					endcase
				end
				S_SCAN: begin
					// one frame compare per cycle, stop at lowest hit
					if (smatch) begin
						hit_q   <= 1'b1;
						hit_f_q <= si;
						state_q <= S_ACT;
					end else if (idx_q == CNT_W'(NUM_FRAMES - 1)) state_q <= S_ACT;
					else idx_q <= idx_q + 1'b1;
				end
				S_ACT: begin
					// hold the result until the order list walk is done
					state_q   <= ocmd.remove ? S_WAIT_ORD : S_OUT;
					out_valid <= !ocmd.remove;
					unique case (func_q)
						FUNC_FETCH, FUNC_NEW: begin
							if (func_q == FUNC_FETCH && hit_q) begin
								if (&pin_q[hit_f_q])
									set_res(ST_PIN_LIMIT, 6'(hit_f_q), 1'b0, '0, '0,
										1'b0, '0, 1'b0, 1'b1);
								else begin
									pin_q[hit_f_q] <= pin_q[hit_f_q] + 1'b1;
									set_res(ST_OK, 6'(hit_f_q), 1'b0, '0, '0,
										1'b0, '0, 1'b0, 1'b1);
								end
							end else if (ostat.count == '0)
								set_res(ST_NO_FRAME, '0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b1);
							else begin
								set_res(ST_OK, 6'(vic), vic_wb,
									vic_wb ? frame_page_q[vic] : '0,
									vic_wb ? 6'(vic) : '0,
									func_q == FUNC_FETCH,
									(func_q == FUNC_FETCH) ? page_q : '0,
									func_q == FUNC_NEW, 1'b1);
								frame_page_q[vic] <= page_q;
								valid_q[vic]      <= 1'b1;
								fdirty_q[vic]     <= 1'b0;
								pin_q[vic]        <= PIN_BITS'(1);
							end
						end
						FUNC_UNPIN: begin
							if (!hit_q)
								set_res(ST_NOT_RES, '0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b1);
							else if (pin_q[hit_f_q] == '0)
								set_res(ST_NOT_PIN, '0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b1);
							else begin
								if (dirty_in_q) fdirty_q[hit_f_q] <= 1'b1;
								pin_q[hit_f_q] <= pin_q[hit_f_q] - 1'b1;
								set_res(ST_OK, '0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b1);
							end
						end
						default: begin
							if (!hit_q)
								set_res(ST_NOT_RES, '0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b1);
							else begin
								fdirty_q[hit_f_q] <= 1'b0;
								set_res(ST_OK, '0, 1'b1, page_q, 6'(hit_f_q),
									1'b0, '0, 1'b0, 1'b1);
							end
						end
					endcase
				end
				S_WAIT_ORD: if (!ostat.busy) begin
					state_q   <= S_OUT;
					out_valid <= 1'b1;
				end
				S_FLUSH: begin
					// one frame per cycle while no result waits on out_ready; emit for each dirty frame
					if (valid_q[si] && fdirty_q[si]) begin
						fdirty_q[si] <= 1'b0;
						set_res(ST_OK, '0, 1'b1, frame_page_q[si], 6'(si),
							1'b0, '0, 1'b0, !more_dirty);
						out_valid <= 1'b1;
						state_q   <= S_OUT;
						done_q    <= !more_dirty;
						idx_q     <= idx_q + 1'b1;
					end else if (idx_q == CNT_W'(NUM_FRAMES - 1)) begin
						// nothing dirty: one empty result
						set_res(ST_OK, '0, 1'b0, '0, '0, 1'b0, '0, 1'b0, 1'b1);
						out_valid <= 1'b1;
						done_q    <= 1'b1;
						state_q   <= S_OUT;
					end else idx_q <= idx_q + 1'b1;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					if (func_q == FUNC_FLUSH_ALL && !last && !done_q) state_q <= S_FLUSH;
					else state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PFP_ASSERT_IMP(a_out_only_in_out, clk, arst_n, out_valid, state_q == S_OUT)
	`PFP_ASSERT_IMP(a_wb_frame_ok, clk, arst_n, out_valid && write_back_valid,
		write_back_frame < 6'(NUM_FRAMES))
	`PFP_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !ostat.busy)
endmodule
`default_nettype wire

/* rtl/pfpl_order.sv */
`default_nettype none
`include "page_frame_pool_lru_unit_defines.svh"
// Eviction order list; remove shifts one entry per cycle.
module pfpl_order (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pfpl_pkg::ord_cmd_t  cmd,
	output pfpl_pkg::ord_stat_t stat
);
	import pfpl_pkg::*;

	logic [IDX_W-1:0] order_q [NUM_FRAMES];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;
	logic             found_q;
	logic             busy_q;
	logic [IDX_W-1:0] frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_FRAMES; i++) order_q[i] <= IDX_W'(i);
			count_q <= CNT_W'(NUM_FRAMES);
			pos_q   <= '0;
			found_q <= 1'b0;
			busy_q  <= 1'b0;
			frame_q <= '0;
		end else if (busy_q) begin
			// walk: search, then shift left over the removed slot
			if (pos_q + 1'b1 >= count_q) begin
				busy_q <= 1'b0;
				if (found_q || order_q[pos_q[IDX_W-1:0]] == frame_q)
					count_q <= count_q - 1'b1;
			end else begin
				if (found_q || order_q[pos_q[IDX_W-1:0]] == frame_q) begin
					found_q <= 1'b1;
					order_q[pos_q[IDX_W-1:0]] <= order_q[pos_q[IDX_W-1:0] + 1'b1];
				end
				pos_q <= pos_q + 1'b1;
			end
		end else if (cmd.remove) begin
			if (count_q != '0) begin
				busy_q  <= 1'b1;
				pos_q   <= '0;
				found_q <= 1'b0;
				frame_q <= cmd.frame;
			end
		end else if (cmd.push) begin
			if (count_q < CNT_W'(NUM_FRAMES)) begin
				for (int i = 1; i < NUM_FRAMES; i++) order_q[i] <= order_q[i-1];
				order_q[0] <= cmd.frame;
				count_q    <= count_q + 1'b1;
			end
		end else if (cmd.pop) begin
			if (count_q != '0) count_q <= count_q - 1'b1;
		end
	end

	always_comb begin
		stat.busy   = busy_q;
		stat.count  = count_q;
		stat.victim = (count_q != '0) ? order_q[IDX_W'(count_q - 1'b1)] : '0;
	end

	`PFP_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(NUM_FRAMES))
	`PFP_ASSERT_IMP(a_pos_range, clk, arst_n, busy_q, pos_q < count_q)
	`PFP_ASSERT_NEXT(a_pop_dec, clk, arst_n,
		!busy_q && !cmd.remove && !cmd.push && cmd.pop && count_q != '0,
		count_q == $past(count_q) - 1'b1)
endmodule
`default_nettype wire
